FILE: design/nsws_pkg.sv
// nsws_pkg: shared constants for the negative sampler with subsampling
// command, result kind and register codes, generator constants
// no dependencies
`default_nettype none
package nsws_pkg;
  localparam logic [1:0] CMD_TABLE = 2'd0;
  localparam logic [1:0] CMD_FREQ  = 2'd1;
  localparam logic [1:0] CMD_WORD  = 2'd2;

  localparam logic [1:0] KIND_KEEP   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_GAVEUP = 2'd2;

  localparam logic [0:0] REG_NEGATIVES = 1'd0;
  localparam logic [0:0] REG_TOTAL     = 1'd1;

  localparam logic [31:0] LCG_MUL_LO = 32'hDEECE66D;
  localparam logic [31:0] LCG_MUL_HI = 32'h00000005;
  localparam logic [63:0] LCG_ADD    = 64'd11;
endpackage
`default_nettype wire

FILE: design/nsws_ram.sv
// nsws_ram: generic single write port, single read port ram
// registered read data, holds when no read is issued
// no dependencies
`default_nettype none
module nsws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/nsws_lcg.sv
// nsws_lcg: 64-bit linear congruential generator, one step per start
// one shared 32x32 multiplier over three partial products
// depends on nsws_pkg
`default_nettype none
module nsws_lcg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output logic             done,
  output logic [63:0]      gen
);
  logic [63:0] acc;
  logic [63:0] prod;
  logic [1:0]  ph;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = gen[31:0];
    mul_b = nsws_pkg::LCG_MUL_LO;
    if (busy && ph == 2'd0) mul_a = gen[63:32];
    if (busy && ph == 2'd1) mul_b = nsws_pkg::LCG_MUL_HI;
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    if (rst) begin
      gen  <= 64'd1;
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        ph   <= 2'd0;
        prod <= mul_p;
      end else if (busy) begin
        case (ph)
          2'd0: begin
            acc  <= prod + nsws_pkg::LCG_ADD;
            prod <= mul_p;
            ph   <= 2'd1;
          end
          2'd1: begin
            acc[63:32] <= acc[63:32] + prod[31:0];
            prod       <= mul_p;
            ph         <= 2'd2;
          end
          default: begin
            gen  <= {acc[63:32] + prod[31:0], acc[31:0]};
            busy <= 1'b0;
            done <= 1'b1;
            ph   <= 2'd0;
          end
        endcase
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/nsws_div.sv
// nsws_div: restoring divider, 48-bit dividend by 32-bit divisor
// one quotient bit per cycle, quotient and remainder held after done
// no dependencies
`default_nettype none
module nsws_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [47:0]      quo,
  output logic [31:0]      rem
);
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] sh;
  logic        ge;

  assign sh = {rem, quo[47]};
  assign ge = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= 32'd0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? 32'(sh - {1'b0, dvs}) : sh[31:0];
        quo <= {quo[46:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/nsws_sqrt.sv
// nsws_sqrt: integer square root of a 32-bit value
// two radicand bits per cycle
// no dependencies
`default_nettype none
module nsws_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] x,
  output logic             busy,
  output logic             done,
  output logic [15:0]      root
);
  logic [31:0] xr;
  logic [31:0] rt;
  logic [3:0]  cnt;
  logic [31:0] bitv;
  logic [31:0] trial;

  assign bitv  = 32'd1 << (5'd30 - {cnt, 1'b0});
  assign trial = rt + bitv;
  assign root  = rt[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 4'd0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 4'd0;
        xr   <= x;
        rt   <= 32'd0;
      end else if (busy) begin
        if (xr >= trial) begin
          xr <= xr - trial;
          rt <= (rt >> 1) + bitv;
        end else begin
          rt <= rt >> 1;
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/negative_sampler_with_subsampling.sv
// Negative sampler with subsampling. Table and frequency writes go straight from the input beat.
// A word with subsampling on takes a generator step, then serial division and the square root
// before its keep beat (a zero frequency or a word outside the vocabulary skips both, a ratio
// of one or more skips the root). Each draw then takes a generator step over a shared 32x32
// multiplier, the modulo in the shared divider when TABLE_DEPTH is not a power of two, a table
// read and a check, after which it draws again or gives a result beat. A result beat waits in
// place while the output holds an untaken beat, and the next draw starts once it is loaded
// into the output register. After reset the frequency store is cleared, one entry a cycle,
// before the first item is taken; configuration writes are taken at any time.
// depends on nsws_pkg, nsws_ram, nsws_lcg, nsws_div, nsws_sqrt
`default_nettype none
module negative_sampler_with_subsampling #(
  parameter int TABLE_DEPTH = 1048576,
  parameter int VOCAB_DEPTH = 65536,
  parameter int MAX_DRAWS   = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // index[19:0], value[51:20], word_id[67:52], zero pad
  input  wire logic [1:0]  s_tuser,  // cmd[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,  // payload[15:0]
  output logic [1:0]       m_tuser,  // kind[1:0]
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  localparam int TAW = $clog2(TABLE_DEPTH);
  localparam int VAW = $clog2(VOCAB_DEPTH);
  localparam int MW  = $clog2(MAX_DRAWS + 1);
  localparam bit TPOW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_K_LCG  = 4'd1;
  localparam logic [3:0] ST_K_DIV  = 4'd2;
  localparam logic [3:0] ST_K_SQRT = 4'd3;
  localparam logic [3:0] ST_K_EMIT = 4'd4;
  localparam logic [3:0] ST_D_LCG  = 4'd5;
  localparam logic [3:0] ST_D_MOD  = 4'd6;
  localparam logic [3:0] ST_D_ADDR = 4'd7;
  localparam logic [3:0] ST_D_CHK  = 4'd8;
  localparam logic [3:0] ST_D_EMIT = 4'd9;

  logic [19:0] in_index;
  logic [31:0] in_value;
  logic [15:0] in_word;
  assign in_index = s_tdata[19:0];
  assign in_value = s_tdata[51:20];
  assign in_word  = s_tdata[67:52];

  logic [3:0]     state, state_next;
  logic [5:0]     negatives;
  logic [47:0]    total;
  logic           clearing;
  logic [VAW-1:0] clr_cnt;
  logic [15:0]    word;
  logic           word_ok;
  logic [15:0]    g16;
  logic           keep;
  logic [5:0]     got;
  logic [MW-1:0]  misses;
  logic [TAW-1:0] pos;
  logic [1:0]     pend_kind;
  logic [15:0]    pend_payload;
  logic           pend_end;

  logic accept, out_free;
  assign s_tready  = (state == ST_IDLE) && !clearing;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  // frequency store
  logic           f_we, f_re;
  logic [VAW-1:0] f_waddr;
  logic [31:0]    f_wdata, f_rdata;
  assign f_we    = clearing || (accept && s_tuser == nsws_pkg::CMD_FREQ &&
                   32'(in_index) < 32'(VOCAB_DEPTH));
  assign f_waddr = clearing ? clr_cnt : VAW'(in_index);
  assign f_wdata = clearing ? 32'd0 : in_value;
  assign f_re    = accept && s_tuser == nsws_pkg::CMD_WORD;

  nsws_ram #(.WIDTH(32), .DEPTH(VOCAB_DEPTH)) u_freq (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(VAW'(in_word)), .rdata(f_rdata)
  );

  // sampling table
  logic        t_we, t_re;
  logic [15:0] t_rdata;
  assign t_we = accept && s_tuser == nsws_pkg::CMD_TABLE &&
                32'(in_index) < 32'(TABLE_DEPTH);
  assign t_re = state == ST_D_ADDR;

  nsws_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_table (
    .clk(clk), .we(t_we), .waddr(TAW'(in_index)), .wdata(in_value[15:0]),
    .re(t_re), .raddr(pos), .rdata(t_rdata)
  );

  // shared units
  logic        lcg_start, lcg_busy, lcg_done;
  logic [63:0] gen;
  logic        div_start, div_busy, div_done;
  logic [47:0] div_quo;
  logic [31:0] div_rem;
  logic        sq_start, sq_busy, sq_done;
  logic [15:0] sq_root;

  nsws_lcg u_lcg (
    .clk(clk), .rst(rst), .start(lcg_start), .busy(lcg_busy), .done(lcg_done), .gen(gen)
  );

  nsws_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(state == ST_K_LCG ? total : gen[63:16]),
    .divisor(state == ST_K_LCG ? f_rdata : 32'(TABLE_DEPTH)),
    .busy(div_busy), .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  nsws_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x({div_quo[15:0], 16'd0}),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  // sequencer
  logic        load_out;
  logic [1:0]  out_kind;
  logic [15:0] out_payload;
  logic        out_last;
  logic        draw_begin;
  logic        hit;
  logic [MW-1:0] misses_inc;
  logic [16:0] keep_sum;

  assign hit        = t_rdata == word;
  assign misses_inc = misses + 1'b1;
  assign keep_sum   = {1'b0, div_quo[15:0]} + {1'b0, sq_root};

  always_comb begin
    state_next  = state;
    lcg_start   = 1'b0;
    div_start   = 1'b0;
    sq_start    = 1'b0;
    load_out    = 1'b0;
    out_kind    = pend_kind;
    out_payload = pend_payload;
    out_last    = pend_end;
    draw_begin  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && s_tuser == nsws_pkg::CMD_WORD) begin
          if (total != 48'd0) begin
            lcg_start  = 1'b1;
            state_next = ST_K_LCG;
          end else if (negatives != 6'd0) begin
            lcg_start  = 1'b1;
            draw_begin = 1'b1;
            state_next = ST_D_LCG;
          end
        end
      end
      ST_K_LCG: begin
        if (lcg_done) begin
          if (f_rdata == 32'd0 || !word_ok) state_next = ST_K_EMIT;
          else begin
            div_start  = 1'b1;
            state_next = ST_K_DIV;
          end
        end
      end
      ST_K_DIV: begin
        if (div_done) begin
          if (div_quo[47:16] != 32'd0) state_next = ST_K_EMIT;
          else begin
            sq_start   = 1'b1;
            state_next = ST_K_SQRT;
          end
        end
      end
      ST_K_SQRT: begin
        if (sq_done) state_next = ST_K_EMIT;
      end
      ST_K_EMIT: begin
        out_kind    = nsws_pkg::KIND_KEEP;
        out_payload = {15'd0, keep};
        out_last    = negatives == 6'd0;
        if (out_free) begin
          load_out = 1'b1;
          if (negatives == 6'd0) state_next = ST_IDLE;
          else begin
            lcg_start  = 1'b1;
            draw_begin = 1'b1;
            state_next = ST_D_LCG;
          end
        end
      end
      ST_D_LCG: begin
        if (lcg_done) begin
          if (TPOW2) state_next = ST_D_ADDR;
          else begin
            div_start  = 1'b1;
            state_next = ST_D_MOD;
          end
        end
      end
      ST_D_MOD: begin
        if (div_done) state_next = ST_D_ADDR;
      end
      ST_D_ADDR: state_next = ST_D_CHK;
      ST_D_CHK: begin
        if (hit && misses_inc != MW'(MAX_DRAWS)) begin
          lcg_start  = 1'b1;
          state_next = ST_D_LCG;
        end else begin
          state_next = ST_D_EMIT;
        end
      end
      ST_D_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (pend_end) state_next = ST_IDLE;
          else begin
            lcg_start  = 1'b1;
            state_next = ST_D_LCG;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      negatives <= 6'd5;
      total     <= 48'd0;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      m_tvalid  <= 1'b0;
      got       <= 6'd0;
      misses    <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == nsws_pkg::REG_NEGATIVES) negatives <= cfg_data[5:0];
        if (cfg_index == nsws_pkg::REG_TOTAL) total <= cfg_data;
      end
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == VAW'(VOCAB_DEPTH - 1)) clearing <= 1'b0;
      end
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (draw_begin) begin
        got    <= 6'd0;
        misses <= '0;
      end
      if (state == ST_D_CHK) begin
        if (hit) begin
          if (misses_inc != MW'(MAX_DRAWS)) misses <= misses_inc;
        end else begin
          misses <= '0;
          got    <= got + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word    <= in_word;
      word_ok <= 32'(in_word) < 32'(VOCAB_DEPTH);
    end
    if (state == ST_K_LCG && lcg_done) begin
      g16  <= gen[15:0];
      keep <= 1'b1;
    end
    if (state == ST_K_SQRT && sq_done) keep <= !(keep_sum < {1'b0, g16});
    if (state == ST_D_LCG && lcg_done && TPOW2) pos <= gen[16 +: TAW];
    if (state == ST_D_MOD && div_done) pos <= TAW'(div_rem);
    if (state == ST_D_CHK) begin
      if (hit) begin
        pend_kind    <= nsws_pkg::KIND_GAVEUP;
        pend_payload <= 16'd0;
        pend_end     <= 1'b1;
      end else begin
        pend_kind    <= nsws_pkg::KIND_SAMPLE;
        pend_payload <= t_rdata;
        pend_end     <= (got + 6'd1) == negatives;
      end
    end
    if (load_out) begin
      m_tuser <= out_kind;
      m_tdata <= out_payload;
      m_tlast <= out_last;
    end
  end

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(lcg_busy && div_busy) && !(div_busy && sq_busy))
    else $error("shared units overlap");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result beat overwritten");

  a_misses_bound: assert property (@(posedge clk) disable iff (rst)
    misses < MW'(MAX_DRAWS))
    else $error("rejection run past limit");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (lcg_busy || div_busy || sq_busy) |-> !s_tready)
    else $error("input taken while busy");
endmodule
`default_nettype wire
